[rtl/prgba_pkg.sv]
// ----------------------------------------------------------------------------
// prgba_pkg
// Shared types and constants for the packed RGB to RGBA converter.
// ----------------------------------------------------------------------------
package prgba_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Depth of the queue between the byte parser and the output stage.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] ALPHA_OPAQUE      = 8'hff;
	localparam logic [7:0] ALPHA_TRANSPARENT = 8'h00;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_ALPHA_PLANE  = 2'd2,
		REG_KEY_COLOR    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        alpha_plane;
		logic [23:0] key_color;
	} cfg_t;

	// One pending pixel write. For an alpha-only write, b2 carries the plane byte.
	typedef struct packed {
		logic [23:0] idx;
		logic        full;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic        done;
	} q_item_t;

endpackage

[rtl/prgba_front.sv]
// ----------------------------------------------------------------------------
// prgba_front
// Byte parser: tracks pixel phase, padding, row and column, and emits one
// pending write per completed color pixel or alpha byte.
// ----------------------------------------------------------------------------
module prgba_front import prgba_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_start,
	input  logic        q_full,
	output logic        push,
	output q_item_t     push_item
);

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);

	logic [1:0]    byte_phase_q, byte_phase_d;
	logic [15:0]   held_q, held_d;
	logic [CW-1:0] column_q, column_d;
	logic [RW-1:0] row_q, row_d;
	logic [23:0]   pixel_cnt_q, pixel_cnt_d;
	logic [1:0]    pad_q, pad_d;
	logic          alpha_pass_q, alpha_pass_d;
	logic          finished_q, finished_d;

	logic [CW-1:0] w;
	logic [RW-1:0] h;
	logic [1:0]    w_lo;

	// Dimensions are clamped to 1..MAX and follow the registers at once.
	always_comb begin
		if (cfg.image_width == '0)
			w = CW'(1);
		else if (32'(cfg.image_width) > MAX_WIDTH)
			w = CW'(MAX_WIDTH);
		else
			w = CW'(cfg.image_width);
		if (cfg.image_height == '0)
			h = RW'(1);
		else if (32'(cfg.image_height) > MAX_HEIGHT)
			h = RW'(MAX_HEIGHT);
		else
			h = RW'(cfg.image_height);
	end

	assign w_lo     = 2'(w);
	assign in_ready = !q_full;

	always_comb begin
		logic [CW-1:0] col_inc;
		logic [RW-1:0] row_inc;
		logic          last;
		byte_phase_d = byte_phase_q;
		held_d       = held_q;
		column_d     = column_q;
		row_d        = row_q;
		pixel_cnt_d  = pixel_cnt_q;
		pad_d        = pad_q;
		alpha_pass_d = alpha_pass_q;
		finished_d   = finished_q;
		push         = 1'b0;
		push_item    = '0;
		col_inc      = '0;
		row_inc      = '0;
		last         = 1'b0;
		if (in_valid && in_ready) begin
			if (in_start) begin
				byte_phase_d = '0;
				held_d       = '0;
				column_d     = '0;
				row_d        = '0;
				pixel_cnt_d  = '0;
				pad_d        = '0;
				alpha_pass_d = 1'b0;
				finished_d   = 1'b0;
			end
			if (finished_d) begin
				// Image complete: bytes are dropped until the next start.
			end else if (pad_d != 2'd0) begin
				pad_d = pad_d - 2'd1;
			end else if (!alpha_pass_d) begin
				case (byte_phase_d)
					2'd0: begin
						held_d       = {8'h00, in_byte};
						byte_phase_d = 2'd1;
					end
					2'd1: begin
						held_d       = {in_byte, held_d[7:0]};
						byte_phase_d = 2'd2;
					end
					default: begin
						byte_phase_d   = 2'd0;
						push           = 1'b1;
						push_item.idx  = pixel_cnt_d;
						push_item.full = 1'b1;
						push_item.b0   = held_d[7:0];
						push_item.b1   = held_d[15:8];
						push_item.b2   = in_byte;
						pixel_cnt_d    = pixel_cnt_d + 24'd1;
						col_inc        = column_d + CW'(1);
						column_d       = col_inc;
						if (col_inc >= w) begin
							column_d = '0;
							row_inc  = row_d + RW'(1);
							row_d    = row_inc;
							pad_d    = w_lo[0] ? 2'd3 : 2'd0;
							last     = (row_inc >= h);
						end
						if (last) begin
							if (cfg.alpha_plane) begin
								alpha_pass_d = 1'b1;
								row_d        = '0;
								column_d     = '0;
								pixel_cnt_d  = '0;
							end else begin
								finished_d     = 1'b1;
								push_item.done = 1'b1;
							end
						end
					end
				endcase
			end else begin
				push           = 1'b1;
				push_item.idx  = pixel_cnt_d;
				push_item.full = 1'b0;
				push_item.b2   = in_byte;
				pixel_cnt_d    = pixel_cnt_d + 24'd1;
				col_inc        = column_d + CW'(1);
				column_d       = col_inc;
				if (col_inc >= w) begin
					column_d = '0;
					row_inc  = row_d + RW'(1);
					row_d    = row_inc;
					// Alpha rows are padded up to a multiple of four bytes.
					pad_d    = 2'(~w_lo + 2'd1);
					if (row_inc >= h) begin
						finished_d     = 1'b1;
						push_item.done = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q <= '0;
			held_q       <= '0;
			column_q     <= '0;
			row_q        <= '0;
			pixel_cnt_q  <= '0;
			pad_q        <= '0;
			alpha_pass_q <= 1'b0;
			finished_q   <= 1'b0;
		end else begin
			byte_phase_q <= byte_phase_d;
			held_q       <= held_d;
			column_q     <= column_d;
			row_q        <= row_d;
			pixel_cnt_q  <= pixel_cnt_d;
			pad_q        <= pad_d;
			alpha_pass_q <= alpha_pass_d;
			finished_q   <= finished_d;
		end
	end

endmodule

[rtl/prgba_queue.sv]
// ----------------------------------------------------------------------------
// prgba_queue
// Short first-in first-out queue of pending pixel writes.
// ----------------------------------------------------------------------------
module prgba_queue import prgba_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    not_empty,
	output q_item_t pop_item
);

	q_item_t                entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]    wr_ptr_q;
	logic [QUEUE_AW-1:0]    rd_ptr_q;
	logic [QUEUE_AW:0]      count_q;

	assign full      = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (push && !pop)
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (QUEUE_AW + 1)'(1);
		end
	end

endmodule

[rtl/prgba_back.sv]
// ----------------------------------------------------------------------------
// prgba_back
// Output stage: applies the color key, forms the alpha byte and holds the
// result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module prgba_back import prgba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_not_empty,
	input  q_item_t     q_item,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [55:0] out_data,
	output logic        out_user,
	output logic        out_last
);

	logic        valid_q;
	logic [23:0] idx_q;
	logic [7:0]  b0_q, b1_q, b2_q, alpha_q;
	logic        full_q, done_q;
	logic        key_hit;
	logic [7:0]  alpha_d;

	// Key byte 0 is compared with pixel byte 2, key byte 2 with pixel byte 0.
	assign key_hit = (cfg.key_color[7:0] == q_item.b2) &&
	                 (cfg.key_color[15:8] == q_item.b1) &&
	                 (cfg.key_color[23:16] == q_item.b0);

	always_comb begin
		if (!q_item.full)
			alpha_d = q_item.b2;
		else if (!cfg.alpha_plane && key_hit)
			alpha_d = ALPHA_TRANSPARENT;
		else
			alpha_d = ALPHA_OPAQUE;
	end

	assign pop = q_not_empty && (!valid_q || out_ready);

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q   <= q_item.idx;
			full_q  <= q_item.full;
			b0_q    <= q_item.full ? q_item.b0 : 8'h00;
			b1_q    <= q_item.full ? q_item.b1 : 8'h00;
			b2_q    <= q_item.full ? q_item.b2 : 8'h00;
			alpha_q <= alpha_d;
			done_q  <= q_item.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	assign out_valid = valid_q;
	assign out_data  = {alpha_q, b2_q, b1_q, b0_q, idx_q};
	assign out_user  = full_q;
	assign out_last  = done_q;

endmodule

[rtl/packed_rgb_to_rgba_converter.sv]
// ----------------------------------------------------------------------------
// packed_rgb_to_rgba_converter
// Turns a packed 3-byte-per-pixel byte stream into 4-byte pixel writes.
// ----------------------------------------------------------------------------
// The input stream carries one source byte per transaction; tuser set marks
// the first byte of a new image and clears all position counters. Every third
// color byte yields a full pixel write (alpha 255, or 0 on a key match without a plane);
// with an alpha plane enabled, each plane byte yields an alpha-only write.
// Row padding and bytes after the final write produce nothing.
// The output stream carries one write per transaction, tlast on the last
// write of the image. Configuration writes go through the cfg channel, which
// is always ready; they are meant to be made while the block is idle.
// One input byte is taken every cycle while the queue is not full. A write
// goes into the queue at the edge that accepts the byte completing it, and
// moves on into the output register once that register is free or being taken.
// A four-entry queue sits between parser and output stage,
// so a stalled receiver holds tvalid and the data steady and input is only
// refused once the queue is full. Reset empties the queue and clears all
// counters; the registers return to width 1, height 1, no plane, key 0.
// ----------------------------------------------------------------------------
module packed_rgb_to_rgba_converter import prgba_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] image_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [23:0] pixel_index, [31:24] byte_zero,
	                               // [39:32] byte_one, [47:40] byte_two,
	                               // [55:48] alpha_value
	output logic        m_tuser,   // [0] full_pixel
	output logic        m_tlast,   // image_done
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cfg_t    cfg_q;
	logic    q_full, q_not_empty, push, pop;
	q_item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'd1;
			cfg_q.image_height <= 13'd1;
			cfg_q.alpha_plane  <= 1'b0;
			cfg_q.key_color    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[12:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[12:0];
				REG_ALPHA_PLANE:  cfg_q.alpha_plane  <= cfg_data[0];
				REG_KEY_COLOR:    cfg_q.key_color    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	prgba_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_start  (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	prgba_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_item  (pop_item)
	);

	prgba_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.q_item      (pop_item),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_user    (m_tuser),
		.out_last    (m_tlast)
	);

endmodule

[test/tb_packed_rgb_to_rgba_converter.sv]
// ----------------------------------------------------------------------------
// tb_packed_rgb_to_rgba_converter
// Self-checking regression for the packed RGB to RGBA converter.
// ----------------------------------------------------------------------------
// Source images are queued byte by byte and fed to the input stream by a
// clocked driver that idles at random. Every accepted byte runs through a
// behavioral copy of the converter, and the pixel write it causes is queued.
// A clocked monitor stalls the output at random and compares each write with
// the oldest queued one. Register settings change between phases only, after
// the pipeline has drained: first a few hand-made images covering color key,
// alpha plane, clamping and register changes in the middle of an image, then
// many random images, truncated images and stray bytes.
// ----------------------------------------------------------------------------
module tb_packed_rgb_to_rgba_converter;
	import prgba_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 100;
	localparam int RANDOM_BYTES   = 820;

	typedef struct packed {
		logic [23:0] pix_idx;
		logic        full;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [7:0]  alpha;
		logic        done;
	} pixel_write_t;

	typedef struct packed {
		logic [7:0] data;
		logic       start;
	} source_byte_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [23:0] cfg_data  = 24'd0;

	source_byte_t source_bytes[$];
	pixel_write_t pending_writes[$];

	int errors       = 0;
	int writes_seen  = 0;
	int bytes_queued = 0;
	int img_len      = 0;
	int cyc          = 0;
	int idle_cycles  = 0;
	int hold_left    = 0;
	bit hold_done    = 0;
	wire quiet = (cyc >= 600) && (cyc < 1100);

	// Register mirror, reset values of the block.
	logic [12:0] cfg_width  = 13'd1;
	logic [12:0] cfg_height = 13'd1;
	logic        cfg_alpha  = 1'b0;
	logic [23:0] cfg_key    = 24'd0;

	// Converter position state.
	logic [1:0]  px_phase;
	logic [7:0]  px_b0;
	logic [7:0]  px_b1;
	int unsigned px_col;
	int unsigned px_row;
	logic [23:0] px_next;
	int unsigned px_pad;
	bit          px_alpha_pass;
	bit          px_finished;

	packed_rgb_to_rgba_converter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
		if (v < 1) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic void clear_position();
		px_phase      = 2'd0;
		px_b0         = 8'h00;
		px_b1         = 8'h00;
		px_col        = 0;
		px_row        = 0;
		px_next       = 24'd0;
		px_pad        = 0;
		px_alpha_pass = 0;
		px_finished   = 0;
	endfunction

	// Advances the converter by one source byte; returns 1 if a write results.
	function automatic bit convert_byte(input logic [7:0] din, input logic start,
			output pixel_write_t wr);
		int unsigned wd;
		int unsigned ht;
		bit          last_write;
		wr = '0;
		last_write = 0;
		if (start)
			clear_position();
		if (px_finished)
			return 0;
		if (px_pad != 0) begin
			px_pad--;
			return 0;
		end
		wd = clamp_dim(cfg_width, DEF_MAX_WIDTH);
		ht = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
		wr.pix_idx = px_next;
		px_next = px_next + 24'd1;
		px_col++;
		if (!px_alpha_pass) begin
			if (px_phase == 2'd0) begin
				px_b0 = din;
				px_phase = 2'd1;
				px_next = px_next - 24'd1;
				px_col--;
				return 0;
			end
			if (px_phase == 2'd1) begin
				px_b1 = din;
				px_phase = 2'd2;
				px_next = px_next - 24'd1;
				px_col--;
				return 0;
			end
			px_phase = 2'd0;
			wr.full  = 1'b1;
			wr.b0    = px_b0;
			wr.b1    = px_b1;
			wr.b2    = din;
			wr.alpha = ALPHA_OPAQUE;
			// The key is stored with the last color byte in its low byte.
			if (!cfg_alpha && cfg_key[7:0] == din && cfg_key[15:8] == px_b1 &&
					cfg_key[23:16] == px_b0)
				wr.alpha = ALPHA_TRANSPARENT;
			if (px_col >= wd) begin
				px_col = 0;
				px_row++;
				px_pad = (wd % 2 == 1) ? 3 : 0;
				last_write = (px_row >= ht);
			end
			if (last_write) begin
				if (cfg_alpha) begin
					px_alpha_pass = 1;
					px_row = 0;
					px_col = 0;
					px_next = 24'd0;
					last_write = 0;
				end else begin
					px_finished = 1;
				end
			end
		end else begin
			wr.alpha = din;
			if (px_col >= wd) begin
				px_col = 0;
				px_row++;
				px_pad = (4 - (wd % 4)) % 4;
				if (px_row >= ht) begin
					last_write = 1;
					px_finished = 1;
				end
			end
		end
		wr.done = last_write;
		return 1;
	endfunction

	function automatic void check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic start);
		source_byte_t sb;
		sb.data  = b;
		sb.start = start;
		source_bytes.push_back(sb);
		bytes_queued++;
		img_len++;
	endfunction

	function automatic void queue_bytes(input logic [7:0] seq[$], input bit start);
		foreach (seq[i])
			push_byte(seq[i], start && i == 0);
	endfunction

	// Queues one image for the current settings, cut short after cap bytes.
	function automatic void queue_image(input int cap);
		int unsigned wd;
		int unsigned ht;
		logic [7:0]  px [3];
		wd = clamp_dim(cfg_width, DEF_MAX_WIDTH);
		ht = clamp_dim(cfg_height, DEF_MAX_HEIGHT);
		img_len = 0;
		for (int r = 0; r < ht && img_len < cap; r++) begin
			for (int c = 0; c < wd && img_len < cap; c++) begin
				if ($urandom_range(0, 3) == 0) begin
					px[0] = cfg_key[23:16];
					px[1] = cfg_key[15:8];
					px[2] = cfg_key[7:0];
				end else begin
					foreach (px[k])
						px[k] = 8'($urandom);
				end
				foreach (px[k])
					push_byte(px[k], img_len == 0);
			end
			if (wd % 2 == 1)
				repeat (3) push_byte(8'($urandom), 1'b0);
		end
		if (cfg_alpha) begin
			for (int r = 0; r < ht && img_len < cap; r++) begin
				for (int c = 0; c < wd && img_len < cap; c++)
					push_byte(8'($urandom), 1'b0);
				repeat ((4 - (wd % 4)) % 4) push_byte(8'($urandom), 1'b0);
			end
		end
		// Stray bytes after a complete image are dropped by the block.
		repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_IMAGE_WIDTH:  cfg_width  = val[12:0];
			REG_IMAGE_HEIGHT: cfg_height = val[12:0];
			REG_ALPHA_PLANE:  cfg_alpha  = val[0];
			REG_KEY_COLOR:    cfg_key    = val;
			default: ;
		endcase
	endtask

	// Unused upper data bits carry random values; the block must ignore them.
	task automatic configure(input logic [12:0] wd, input logic [12:0] ht,
			input bit plane, input logic [23:0] key);
		logic [23:0] v;
		v = 24'($urandom);
		v[12:0] = wd;
		write_reg(REG_IMAGE_WIDTH, v);
		v = 24'($urandom);
		v[12:0] = ht;
		write_reg(REG_IMAGE_HEIGHT, v);
		v = 24'($urandom);
		v[0] = plane;
		write_reg(REG_ALPHA_PLANE, v);
		write_reg(REG_KEY_COLOR, key);
	endtask

	// Checked at the falling edge so that the rising-edge processes have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (source_bytes.size() != 0 || s_tvalid || pending_writes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	always @(posedge clk) begin : source_driver
		pixel_write_t wr;
		source_byte_t sb;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (convert_byte(s_tdata, s_tuser, wr))
					pending_writes.push_back(wr);
			end
			if (!s_tvalid || s_tready) begin
				if (source_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
					sb = source_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= sb.data;
					s_tuser  <= sb.start;
				end else begin
					s_tvalid <= 1'b0;
					s_tdata  <= 8'($urandom);
					s_tuser  <= 1'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin : write_monitor
		pixel_write_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				writes_seen++;
				if (pending_writes.size() == 0) begin
					errors++;
					$display("%0t: unexpected write, expected none, actual %0h", $time, m_tdata);
				end else begin
					want = pending_writes.pop_front();
					check_field("pixel_index", want.pix_idx, m_tdata[23:0]);
					check_field("byte_zero", 24'(want.b0), 24'(m_tdata[31:24]));
					check_field("byte_one", 24'(want.b1), 24'(m_tdata[39:32]));
					check_field("byte_two", 24'(want.b2), 24'(m_tdata[47:40]));
					check_field("alpha_value", 24'(want.alpha), 24'(m_tdata[55:48]));
					check_field("full_pixel", 24'(want.full), 24'(m_tuser));
					check_field("image_done", 24'(want.done), 24'(m_tlast));
				end
			end
			// One long stall while the source keeps offering, to fill the block.
			if (hold_left > 0) begin
				hold_left--;
			end else if (!hold_done && writes_seen >= 150 && s_tvalid) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			m_tready <= (hold_left == 0) && (quiet || $urandom_range(0, 99) >= 15);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("packed_rgb_to_rgba_converter regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [7:0]  seq[$];
		logic [12:0] wd;
		logic [12:0] ht;
		logic [23:0] key;
		int          cap;
		clear_position();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: one black pixel matches the zero key, then a stray byte.
		seq = {8'h00, 8'h00, 8'h00, 8'hff};
		queue_bytes(seq, 1'b1);
		wait_drained();

		// Zero width and height clamp to one; with a plane the key is not tested,
		// and the padding of the last color row comes before the plane bytes.
		configure(13'd0, 13'd0, 1'b1, 24'hffffff);
		seq = {8'hff, 8'hff, 8'hff, 8'h5a, 8'ha5, 8'h00, 8'h80};
		queue_bytes(seq, 1'b1);
		wait_drained();

		// Height and plane changed between the rows of one image.
		configure(13'd2, 13'd8191, 1'b0, 24'h010203);
		seq = {8'h01, 8'h02, 8'h03, 8'h03, 8'h02, 8'h01};
		queue_bytes(seq, 1'b1);
		wait_drained();
		write_reg(REG_IMAGE_HEIGHT, 24'd1);
		write_reg(REG_ALPHA_PLANE, 24'd1);
		seq = {8'haa, 8'hbb, 8'hcc, 8'h01, 8'h02, 8'h03, 8'h00, 8'hff, 8'h77};
		queue_bytes(seq, 1'b0);
		wait_drained();

		bytes_queued = 0;
		while (bytes_queued < RANDOM_BYTES) begin
			case ($urandom_range(0, 9))
				0: wd = 13'd0;
				1: wd = 13'd8191;
				2: wd = 13'd4096;
				3: wd = 13'd4097;
				default: wd = 13'($urandom_range(1, 7));
			endcase
			case ($urandom_range(0, 9))
				0: ht = 13'd0;
				1: ht = 13'd8191;
				default: ht = 13'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 7))
				0: key = 24'h000000;
				1: key = 24'hffffff;
				default: key = 24'($urandom);
			endcase
			configure(wd, ht, 1'($urandom), key);
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 9) == 0) begin
					// Noise: random bytes with an occasional image start.
					repeat ($urandom_range(4, 30))
						push_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end else begin
					if (wd > 13'd16 || ht > 13'd16)
						cap = $urandom_range(30, 150);
					else if ($urandom_range(0, 4) == 0)
						cap = $urandom_range(1, 40);
					else
						cap = 1 << 30;
					queue_image(cap);
				end
			end
			wait_drained();
		end

		wait_drained();
		if (errors == 0)
			$display("packed_rgb_to_rgba_converter regression: pass");
		else
			$display("packed_rgb_to_rgba_converter regression: fail");
		$finish;
	end

endmodule

[packed_rgb_to_rgba_converter.f]
rtl/prgba_pkg.sv
rtl/prgba_front.sv
rtl/prgba_queue.sv
rtl/prgba_back.sv
rtl/packed_rgb_to_rgba_converter.sv
test/tb_packed_rgb_to_rgba_converter.sv
